// ----- rtl/btp_pkg.sv -----
// Package for the thinning pass: register indexes, result type and the pixel decision.
package btp_pkg;

	localparam int PIXEL_W = 8;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_INDEX_W = 2;
	localparam int ROW_W = 12;
	localparam int FWIDTH_W = 11;

	localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PASS_SELECT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd3;

	localparam logic [PIXEL_W-1:0] THRESHOLD_RST = 8'd1;
	localparam logic [FWIDTH_W-1:0] FRAME_WIDTH_RST = 11'd1024;
	localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST = 12'd1024;

	typedef struct packed {
		logic kept;
		logic removed;
		logic last;
		logic changed;
	} btp_result_t;

	// Columns are three bits: bit 0 top, bit 1 middle, bit 2 bottom.
	function automatic logic thin_decide(input logic [2:0] left, input logic [2:0] mid,
			input logic [2:0] right, input logic pass_sel);
		logic p, n0, n1, n2, n3, n4, n5, n6, n7;
		logic [2:0] cn, a, b, nmin;
		logic corner;
		p = mid[1];
		n0 = left[0]; n7 = left[1]; n6 = left[2];
		n1 = mid[0]; n5 = mid[2];
		n2 = right[0]; n3 = right[1]; n4 = right[2];
		cn = {2'b00, ~n1 & (n2 | n3)} + {2'b00, ~n3 & (n4 | n5)}
			+ {2'b00, ~n5 & (n6 | n7)} + {2'b00, ~n7 & (n0 | n1)};
		a = {2'b00, n0 | n1} + {2'b00, n2 | n3} + {2'b00, n4 | n5} + {2'b00, n6 | n7};
		b = {2'b00, n1 | n2} + {2'b00, n3 | n4} + {2'b00, n5 | n6} + {2'b00, n7 | n0};
		nmin = (a < b) ? a : b;
		if (pass_sel) begin
			corner = (n5 | n6 | ~n0) & n7;
		end else begin
			corner = (n1 | n2 | ~n4) & n3;
		end
		return p && (cn == 3'd1) && (nmin == 3'd2 || nmin == 3'd3) && !corner;
	endfunction

endpackage

// ----- rtl/btp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module btp_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/binary_thinning_pass.sv -----
// One Guo-Hall thinning sub-iteration over a raster pixel stream.
//
// Pixels enter one per clock on pix_valid/pix_ready and are binarized against threshold.
// A line store of MAX_WIDTH entries keeps the two rows above, and a 3x3 window forms the
// neighborhood of pixel (r,c-1) when pixel (r+1,c) arrives. An input transaction can be
// taken every cycle while the consumer keeps up. The first input row yields no results;
// in later rows the first pixel yields no result and the last pixel yields two, so a row
// of W input pixels gives W results and the frame gives one result per real pixel. A
// result reaches the result port through stage 1 and the result buffer: the accepting
// edge loads stage 1 and the line store read, and the edge at which stage 1 fires loads
// the result buffer. A two-entry result buffer without room for the new results stalls
// stage 1 and the input. After the frame_height real rows the host sends one padding
// row of frame_width items; the final result carries last_pixel and frame_changed. The
// line store needs no clearing after reset: reads in a frame's first rows are masked.
module binary_thinning_pass
	import btp_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   pix_valid,
	output logic                   pix_ready,
	input  logic [PIXEL_W-1:0]     pixel_value,
	output logic                   res_valid,
	input  logic                   res_ready,
	output logic                   kept_pixel,
	output logic                   pixel_removed,
	output logic                   last_pixel,
	output logic                   frame_changed
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = (CW + 1 > FWIDTH_W) ? CW + 1 : FWIDTH_W;

	// Configuration registers.
	logic [PIXEL_W-1:0]  threshold_q;
	logic                pass_select_q;
	logic [FWIDTH_W-1:0] frame_width_q;
	logic [ROW_W-1:0]    frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			pass_select_q <= 1'b0;
			frame_width_q <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: threshold_q <= cfg_data[PIXEL_W-1:0];
				REG_PASS_SELECT: pass_select_q <= cfg_data[0];
				REG_FRAME_WIDTH: frame_width_q <= cfg_data[FWIDTH_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective frame size and input position.
	logic [EW-1:0]    w_ext, w_eff, w_last_ext;
	logic [CW-1:0]    w_last, col_q, col_cur;
	logic [ROW_W-1:0] h_eff, row_q;
	logic             acc, fire;
	logic             at_last_col, at_pad_row, cur_bit;

	assign w_ext = EW'(frame_width_q);
	assign w_eff = (w_ext == '0) ? EW'(1) : ((w_ext > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : w_ext);
	assign w_last_ext = w_eff - EW'(1);
	assign w_last = w_last_ext[CW-1:0];
	assign col_cur = (col_q >= w_last) ? w_last : col_q;
	assign h_eff = (frame_height_q == '0) ? ROW_W'(1) : frame_height_q;
	assign at_last_col = (col_cur == w_last);
	assign at_pad_row = (row_q >= h_eff);
	assign cur_bit = !at_pad_row && (pixel_value >= threshold_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (at_last_col) begin
				col_q <= '0;
				row_q <= at_pad_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_cur + CW'(1);
			end
		end
	end

	// Stage 1: the accepted pixel, its position flags and the line store read.
	logic          v_s1, cur_s1, first_s1, lastcol_s1, ends_s1, rge1_s1, rge2_s1;
	logic [CW-1:0] col_s1;
	logic          byp_s1;
	logic [1:0]    byp_data_s1;
	logic [1:0]    ram_rdata, pair_s1;

	// The line store holds {older row, newer row} per column.
	assign pair_s1 = byp_s1 ? byp_data_s1 : ram_rdata;

	btp_ram #(
		.WIDTH(2),
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk  (clk),
		.we   (fire),
		.waddr(col_s1),
		.wdata({pair_s1[0], cur_s1}),
		.re   (acc),
		.raddr(col_cur),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			byp_s1 <= 1'b0;
		end else begin
			if (acc) begin
				v_s1 <= 1'b1;
				// A write to the same column in this cycle is not yet visible in the RAM.
				byp_s1 <= fire && (col_s1 == col_cur);
			end else if (fire) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cur_s1 <= cur_bit;
			col_s1 <= col_cur;
			first_s1 <= (col_cur == '0);
			lastcol_s1 <= at_last_col;
			ends_s1 <= at_pad_row;
			rge1_s1 <= (row_q >= ROW_W'(1));
			rge2_s1 <= (row_q >= ROW_W'(2));
			byp_data_s1 <= {pair_s1[0], cur_s1};
		end
	end

	// Window and pixel decisions.
	logic [5:0]  window_q;
	logic        any_q;
	logic [2:0]  col_bits, win_left, win_mid;
	logic        rem0, rem1, res0_v, res1_v, any_all;
	btp_result_t res0, res1;

	assign col_bits = {cur_s1, rge1_s1 & pair_s1[0], rge2_s1 & pair_s1[1]};
	assign win_left = first_s1 ? 3'b000 : window_q[2:0];
	assign win_mid = first_s1 ? 3'b000 : window_q[5:3];
	assign res0_v = rge1_s1 && !first_s1;
	assign res1_v = rge1_s1 && lastcol_s1;
	assign rem0 = res0_v && thin_decide(win_left, win_mid, col_bits, pass_select_q);
	assign rem1 = res1_v && thin_decide(win_mid, col_bits, 3'b000, pass_select_q);
	assign any_all = any_q | rem0 | rem1;

	always_comb begin
		res0.kept = win_mid[1] & ~rem0;
		res0.removed = rem0;
		res0.last = 1'b0;
		res0.changed = 1'b0;
		res1.kept = col_bits[1] & ~rem1;
		res1.removed = rem1;
		res1.last = ends_s1;
		res1.changed = ends_s1 & any_all;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			any_q <= 1'b0;
		end else if (fire) begin
			window_q <= lastcol_s1 ? 6'b000000 : {col_bits, win_mid};
			any_q <= (lastcol_s1 && ends_s1) ? 1'b0 : any_all;
		end
	end

	// Two-entry result buffer; the head drives the result port.
	logic        head_v_q, tail_v_q, pop;
	btp_result_t head_q, tail_q, rest0, e0, e1;
	logic [1:0]  n_rest, n_new;

	assign pop = head_v_q && res_ready;
	assign n_rest = {1'b0, head_v_q} + {1'b0, tail_v_q} - {1'b0, pop};
	assign rest0 = pop ? tail_q : head_q;
	assign n_new = {1'b0, res0_v} + {1'b0, res1_v};
	assign fire = v_s1 && ({1'b0, n_rest} + {1'b0, n_new} <= 3'd2);
	assign acc = pix_valid && pix_ready;
	assign pix_ready = !v_s1 || fire;

	always_comb begin
		e0 = res0_v ? res0 : res1;
		e1 = res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			tail_v_q <= 1'b0;
		end else begin
			if (n_rest == 2'd0) begin
				head_v_q <= fire && (n_new != 2'd0);
				tail_v_q <= fire && (n_new == 2'd2);
			end else if (n_rest == 2'd1) begin
				head_v_q <= 1'b1;
				tail_v_q <= fire && (n_new != 2'd0);
			end else begin
				head_v_q <= 1'b1;
				tail_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (n_rest == 2'd0) begin
			head_q <= e0;
			tail_q <= e1;
		end else if (n_rest == 2'd1) begin
			head_q <= rest0;
			tail_q <= e0;
		end
	end

	assign res_valid = head_v_q;
	assign kept_pixel = head_q.kept;
	assign pixel_removed = head_q.removed;
	assign last_pixel = head_q.last;
	assign frame_changed = head_q.changed;

endmodule

// ----- rtl/btp_checker.sv -----
// Port-level checks for the thinning pass, bound to the top level.
module btp_checker (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input logic kept_pixel,
	input logic pixel_removed,
	input logic last_pixel,
	input logic frame_changed
);

	// The frame summary only rides on the final result of a frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_changed |-> last_pixel)
		else $error("frame_changed set on a result that is not the last pixel");

	// A cleared pixel cannot also be reported as kept.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(kept_pixel && pixel_removed))
		else $error("pixel both kept and removed");

	// A stalled result transaction holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(kept_pixel)
			&& $stable(pixel_removed) && $stable(last_pixel) && $stable(frame_changed))
		else $error("result changed while stalled");

endmodule

bind binary_thinning_pass btp_checker u_btp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res_valid),
	.res_ready    (res_ready),
	.kept_pixel   (kept_pixel),
	.pixel_removed(pixel_removed),
	.last_pixel   (last_pixel),
	.frame_changed(frame_changed)
);
